// File: rtl/core/fct_pkg.sv
// fct_pkg: shared types and constants of the fat16 cluster table engine
// table geometry, entry codes, request kinds, status codes, sequencer states
// no dependencies
package fct_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int TBL_M2        = TABLE_ENTRIES - 2;
    localparam int CNT_W         = 12;
    localparam int CLU_W         = 16;

    localparam logic [CLU_W-1:0] ENTRY_FREE    = 16'h0000;
    localparam logic [CLU_W-1:0] ENTRY_EOC     = 16'hFFFF;
    localparam logic [CLU_W-1:0] CHAIN_END_MIN = 16'hFFF8;
    localparam logic [CLU_W-1:0] FIRST_DATA    = 16'd2;
    localparam logic [CNT_W-1:0] COUNT_RESET   = 12'd4094;

    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_ALLOC = 2'd2,
        K_FREE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_LONG  = 2'd3
    } t_status;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_RD_ISSUE  = 10'b0000000100,
        S_RD_DATA   = 10'b0000001000,
        S_SCAN_RD   = 10'b0000010000,
        S_SCAN_CHK  = 10'b0000100000,
        S_LINK      = 10'b0001000000,
        S_FREE_TEST = 10'b0010000000,
        S_FREE_CHK  = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } t_state;

    // cluster number lies inside the table
    function automatic logic in_table(input logic [CLU_W-1:0] c);
        in_table = ({1'b0, c} < (CLU_W+1)'(TABLE_ENTRIES));
    endfunction

endpackage

// File: rtl/core/fct_ram.sv
// fct_ram: generic single write port, single read port ram
// registered read data, no dependencies
module fct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/fat16_cluster_table_engine_unit.sv
// fat16_cluster_table_engine_unit: top level of the fat16 cluster table engine
// sequencer around one table ram; uses fct_pkg and fct_ram
//
// The block keeps a FAT16 allocation table of TABLE_ENTRIES 16-bit entries in one
// ram with a single read and a single write port, and serves one request at a
// time: read entry, write entry, first-fit allocate, or free chain. Each request
// gives exactly one result transfer. After reset the block runs a clearing pass
// that zeroes the table; o_in_stall is high during it, while cluster_count writes
// are taken at any time. The ram read port takes one address per cycle and gives
// its registered data in the cycle after. Allocate scans entries from cluster 2
// and may then write a link; free chain zeroes one entry after another. Only one
// request is in work; a new one is taken as soon as the previous result sits
// in the output register, even if that result is still stalled.
module fat16_cluster_table_engine_unit
    import fct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_kind,
    input  logic [CLU_W-1:0] i_cluster,
    input  logic [CLU_W-1:0] i_value,
    input  logic [CLU_W-1:0] i_link_from,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [CLU_W-1:0] o_result_value,
    output logic [1:0]       o_status
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cluster_count;
    logic [TBL_AW-1:0]  r_clr_addr;
    logic [CLU_W-1:0]   r_cur, n_cur;        // cluster under work
    logic [CLU_W-1:0]   r_link, n_link;
    logic [CNT_W-1:0]   r_left, n_left;      // entries still to scan
    logic [TBL_AW:0]    r_visited, n_visited;
    logic [CLU_W-1:0]   r_res, n_res;
    t_status            r_st, n_st;
    logic               r_out_valid;
    logic [CLU_W-1:0]   r_out_value;
    t_status            r_out_status;

    // ram port
    logic               mem_we;
    logic [TBL_AW-1:0]  mem_waddr;
    logic [CLU_W-1:0]   mem_wdata;
    logic [CLU_W-1:0]   mem_rdata;

    logic               in_xfer;
    logic               out_load;
    logic [CNT_W-1:0]   scan_n;
    logic               free_walk;

    fct_ram #(
        .WIDTH (CLU_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cur[TBL_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    // result ready and output register free or being emptied this cycle
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // scan length: smaller of the configured count and the table's data area
    assign scan_n = ((CNT_W+17)'(r_cluster_count) > (CNT_W+17)'(TBL_M2)) ?
                    CNT_W'(TBL_M2) : r_cluster_count;

    // free chain keeps walking while the link is a data cluster
    assign free_walk = (r_cur >= FIRST_DATA) && (r_cur < CHAIN_END_MIN);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_link    = r_link;
        n_left    = r_left;
        n_visited = r_visited;
        n_res     = r_res;
        n_st      = r_st;
        mem_we    = 1'b0;
        mem_waddr = r_cur[TBL_AW-1:0];
        mem_wdata = ENTRY_FREE;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur     = i_cluster;
                    n_link    = i_link_from;
                    n_visited = '0;
                    n_res     = ENTRY_FREE;
                    n_st      = ST_OK;
                    case (t_kind'(i_kind))
                        K_READ: begin
                            if (in_table(i_cluster)) begin
                                n_state = S_RD_ISSUE;
                            end else begin
                                n_st    = ST_RANGE;
                                n_state = S_DONE;
                            end
                        end
                        K_WRITE: begin
                            if (in_table(i_cluster)) begin
                                mem_we    = 1'b1;
                                mem_waddr = i_cluster[TBL_AW-1:0];
                                mem_wdata = i_value;
                            end else begin
                                n_st = ST_RANGE;
                            end
                            n_state = S_DONE;
                        end
                        K_ALLOC: begin
                            n_cur  = FIRST_DATA;
                            n_left = scan_n;
                            if (scan_n == '0) begin
                                n_st    = ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        K_FREE: begin
                            n_state = S_FREE_TEST;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_ISSUE: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_res   = mem_rdata;
                n_state = S_DONE;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (mem_rdata == ENTRY_FREE) begin
                    // first free entry: mark end of chain and hand it out
                    mem_we    = 1'b1;
                    mem_wdata = ENTRY_EOC;
                    n_res     = r_cur;
                    if (r_link == ENTRY_FREE) begin
                        n_state = S_DONE;
                    end else if (in_table(r_link)) begin
                        n_state = S_LINK;
                    end else begin
                        n_st    = ST_RANGE;
                        n_state = S_DONE;
                    end
                end else if (r_left == CNT_W'(1)) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_cur   = r_cur + CLU_W'(1);
                    n_left  = r_left - CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_LINK: begin
                // a self link overwrites the end of chain mark just written
                mem_we    = 1'b1;
                mem_waddr = r_link[TBL_AW-1:0];
                mem_wdata = r_cur;
                n_state   = S_DONE;
            end
            S_FREE_TEST: begin
                // the ram read of r_cur is issued in this cycle
                if (!free_walk) begin
                    n_state = S_DONE;
                end else if (!in_table(r_cur)) begin
                    n_st    = ST_RANGE;
                    n_state = S_DONE;
                end else if (r_visited == (TBL_AW+1)'(TABLE_ENTRIES)) begin
                    n_st    = ST_LONG;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                mem_we    = 1'b1;
                mem_wdata = ENTRY_FREE;
                n_cur     = mem_rdata;
                n_visited = r_visited + (TBL_AW+1)'(1);
                n_state   = S_FREE_TEST;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_addr      <= '0;
            r_cluster_count <= COUNT_RESET;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + TBL_AW'(1);
            end
            if (i_cfg_we) begin
                r_cluster_count <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_link    <= n_link;
        r_left    <= n_left;
        r_visited <= n_visited;
        r_res     <= n_res;
        r_st      <= n_st;
        if (out_load) begin
            r_out_value  <= r_res;
            r_out_status <= r_st;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

    // no result may appear while the table is still being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result transfer offered during clearing pass");

    // an accepted request leaves the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("request taken without leaving idle");

    // a table full result never carries a cluster number
    a_full_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_result_value == ENTRY_FREE))
        else $error("table full result with nonzero cluster");

    // chain walk never counts past the table size
    a_visit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FREE_TEST) || (r_state == S_FREE_CHK)) |->
        (r_visited <= (TBL_AW+1)'(TABLE_ENTRIES)))
        else $error("free chain visit count overran the table");

    // a new result is loaded only when the previous one has left
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_value)))
        else $error("stalled result overwritten");

endmodule

// File: tb/fat16_cluster_table_engine_unit_checker.sv
// fat16_cluster_table_engine_unit_checker: watches the request, result and config ports
// keeps its own copy of the cluster table, predicts each result, compares in order
// depends on fct_pkg
`timescale 1ns / 100ps

module fat16_cluster_table_engine_unit_checker
    import fct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [1:0]       i_kind,
    input  logic [CLU_W-1:0] i_cluster,
    input  logic [CLU_W-1:0] i_value,
    input  logic [CLU_W-1:0] i_link_from,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [CLU_W-1:0] i_result_value,
    input  logic [1:0]       i_status,
    output int               o_pending,
    output int               o_fail_count
);

    localparam int FAT16_CLUSTER_CAP = 65524;

    typedef struct packed {
        logic [CLU_W-1:0] value;
        t_status          status;
    } t_fat_result;

    logic [CLU_W-1:0] fat_shadow [TABLE_ENTRIES];
    int               cluster_limit;
    t_fat_result      due_results [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns  table check: %s", $time, msg);
        o_fail_count++;
    endtask

    // one request against the shadow table
    task automatic apply_table_request(
        input  t_kind            kind,
        input  logic [CLU_W-1:0] cl,
        input  logic [CLU_W-1:0] val,
        input  logic [CLU_W-1:0] link,
        output t_fat_result      res
    );
        int walk;
        int next_c;
        int visited;
        int span;
        bit done;
        res.value  = ENTRY_FREE;
        res.status = ST_OK;
        done       = 1'b0;
        case (kind)
            K_READ: begin
                if (cl < TABLE_ENTRIES) res.value = fat_shadow[cl];
                else res.status = ST_RANGE;
            end
            K_WRITE: begin
                if (cl < TABLE_ENTRIES) fat_shadow[cl] = val;
                else res.status = ST_RANGE;
            end
            K_ALLOC: begin
                // first fit over the usable window only
                span = cluster_limit;
                if (span > FAT16_CLUSTER_CAP) span = FAT16_CLUSTER_CAP;
                if (span > TBL_M2) span = TBL_M2;
                res.status = ST_FULL;
                for (walk = 2; walk < span + 2 && !done; walk++) begin
                    if (fat_shadow[walk] == ENTRY_FREE) begin
                        done       = 1'b1;
                        fat_shadow[walk] = ENTRY_EOC;
                        res.value  = walk[CLU_W-1:0];
                        res.status = ST_OK;
                        if (link != 0) begin
                            if (link < TABLE_ENTRIES) fat_shadow[link] = walk[CLU_W-1:0];
                            else res.status = ST_RANGE;
                        end
                    end
                end
            end
            default: begin
                walk    = int'(cl);
                visited = 0;
                while (!done && walk >= 2 && walk < CHAIN_END_MIN) begin
                    if (walk >= TABLE_ENTRIES) begin
                        res.status = ST_RANGE;
                        done       = 1'b1;
                    end else if (visited >= TABLE_ENTRIES) begin
                        res.status = ST_LONG;
                        done       = 1'b1;
                    end else begin
                        next_c           = int'(fat_shadow[walk]);
                        fat_shadow[walk] = ENTRY_FREE;
                        visited++;
                        walk = next_c;
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_fat_result want;
        int          idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < TABLE_ENTRIES; idx++) fat_shadow[idx] = ENTRY_FREE;
            cluster_limit = int'(COUNT_RESET);
            due_results.delete();
        end else begin
            if (i_cfg_we) cluster_limit = int'(i_cfg_wdata);
            if (i_in_valid && !i_in_stall) begin
                apply_table_request(t_kind'(i_kind), i_cluster, i_value, i_link_from, want);
                due_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %h status %0d",
                                              i_result_value, i_status));
                end else begin
                    want = due_results.pop_front();
                    if (i_result_value !== want.value)
                        report_mismatch($sformatf("result value %h, expected %h",
                                                  i_result_value, want.value));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

// File: tb/fat16_cluster_table_engine_unit_tb.sv
// fat16_cluster_table_engine_unit_tb: stimulus and verdict for the cluster table engine
// drives requests, config and result stalls; checking lives in the checker module
// depends on fct_pkg, fat16_cluster_table_engine_unit, fat16_cluster_table_engine_unit_checker
`timescale 1ns / 100ps

module fat16_cluster_table_engine_unit_tb;
    import fct_pkg::*;

    // worst run: every request a full scan or walk of the table, plus clearing pass
    // and idling, times several; limit in ns with a 10 ns clock period
    localparam longint RUN_LIMIT_NS = 64'd300_000_000;
    localparam int     PHASES       = 9;
    localparam int     PHASE_ITEMS  = 75;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [1:0]       i_kind;
    logic [CLU_W-1:0] i_cluster;
    logic [CLU_W-1:0] i_value;
    logic [CLU_W-1:0] i_link_from;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [CLU_W-1:0] o_result_value;
    logic [1:0]       o_status;

    int pending;
    int fail_total;
    bit idle_on;       // both sides idle at random while set
    int stim_count;    // cluster_count as last written, shapes the random clusters

    fat16_cluster_table_engine_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_cluster      (i_cluster),
        .i_value        (i_value),
        .i_link_from    (i_link_from),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    fat16_cluster_table_engine_unit_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_cluster      (i_cluster),
        .i_value        (i_value),
        .i_link_from    (i_link_from),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_result_value (o_result_value),
        .i_status       (o_status),
        .o_pending      (pending),
        .o_fail_count   (fail_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a transfer never completes
    initial begin
        #(RUN_LIMIT_NS);
        $display("[fat16_cluster_table_engine_unit] ERROR");
        $finish;
    end

    // one request transfer; valid stays up between back-to-back requests so it is
    // never dropped and raised in the same step
    task automatic send_request(
        input t_kind            kind,
        input logic [CLU_W-1:0] cl,
        input logic [CLU_W-1:0] val,
        input logic [CLU_W-1:0] link
    );
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_cluster   <= cl;
        i_value     <= val;
        i_link_from <= link;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // stop sending and wait until every result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // only called with the engine idle
    task automatic set_cluster_count(input int count);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        stim_count = count;
    endtask

    // random request, clusters mostly near the allocatable window so chains form,
    // get linked, walked and freed; the rest spread over the table and beyond
    task automatic send_random_request();
        int               region_hi;
        int               pick;
        t_kind            kind;
        logic [CLU_W-1:0] cl;
        logic [CLU_W-1:0] val;
        logic [CLU_W-1:0] link;
        region_hi = stim_count + 3;
        if (region_hi > TABLE_ENTRIES - 1) region_hi = TABLE_ENTRIES - 1;

        pick = $urandom_range(0, 99);
        if (pick < 25) kind = K_READ;
        else if (pick < 40) kind = K_WRITE;
        else if (pick < 80) kind = K_ALLOC;
        else kind = K_FREE;

        pick = $urandom_range(0, 99);
        if (pick < 70) cl = CLU_W'($urandom_range(0, region_hi));
        else if (pick < 85) cl = CLU_W'($urandom_range(0, TABLE_ENTRIES - 1));
        else if (pick < 93) cl = CLU_W'($urandom_range(TABLE_ENTRIES, 65535));
        else cl = CLU_W'($urandom_range(CHAIN_END_MIN, 16'hFFFF));

        // entry values: links, end of chain, free, reserved end marks, off-table
        pick = $urandom_range(0, 99);
        if (pick < 30) val = CLU_W'($urandom_range(2, region_hi));
        else if (pick < 50) val = ENTRY_EOC;
        else if (pick < 65) val = ENTRY_FREE;
        else if (pick < 75) val = CLU_W'($urandom_range(CHAIN_END_MIN, 16'hFFFE));
        else if (pick < 85) val = CLU_W'($urandom_range(TABLE_ENTRIES, CHAIN_END_MIN - 1));
        else val = CLU_W'($urandom_range(0, 65535));

        pick = $urandom_range(0, 99);
        if (pick < 35) link = '0;
        else if (pick < 85) link = CLU_W'($urandom_range(2, region_hi));
        else if (pick < 95) link = CLU_W'($urandom_range(TABLE_ENTRIES, 65535));
        else link = CLU_W'($urandom_range(0, 65535));

        send_request(kind, cl, val, link);
    endtask

    // result side: per transfer, stall a random number of cycles, then accept
    initial begin : result_sink
        int hold;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = idle_on ? $urandom_range(0, 12) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : stimulus
        int count_plan [PHASES];
        int phase;
        int item;
        count_plan = '{1, 0, 6, 4094, 17, 64, 0, 250, 4094};
        count_plan[6] = $urandom_range(2, 500);

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= K_READ;
        i_cluster   <= '0;
        i_value     <= '0;
        i_link_from <= '0;
        idle_on     = 1'b1;
        stim_count  = int'(COUNT_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset cluster count; the clearing pass after reset
        // just holds off the first transfer
        send_request(K_READ,  16'd0,     16'h0000, 16'h0000); // cleared table
        send_request(K_READ,  16'd4095,  16'h0000, 16'h0000); // last entry
        send_request(K_READ,  16'd4096,  16'h0000, 16'h0000); // first cluster off the table
        send_request(K_READ,  16'hFFFF,  16'h0000, 16'h0000);
        send_request(K_WRITE, 16'd4095,  16'hFFFF, 16'h0000);
        send_request(K_WRITE, 16'd4096,  16'hAAAA, 16'h0000); // off table, nothing stored
        send_request(K_WRITE, 16'd0,     16'h5555, 16'h0000); // reserved entries still writable
        send_request(K_WRITE, 16'd1,     16'hFFF8, 16'h0000);
        send_request(K_READ,  16'd0,     16'h0000, 16'h0000);
        send_request(K_ALLOC, 16'd0,     16'h0000, 16'h0000); // plain allocate
        send_request(K_ALLOC, 16'd0,     16'h0000, 16'd2);    // linked to the previous one
        send_request(K_ALLOC, 16'd0,     16'h0000, 16'hFFFF); // link off table, still allocated
        send_request(K_ALLOC, 16'd0,     16'h0000, 16'd5);    // link to itself
        send_request(K_ALLOC, 16'd0,     16'h0000, 16'd4095); // link from the last entry
        send_request(K_ALLOC, 16'd0,     16'h0000, 16'd4096);
        send_request(K_FREE,  16'd0,     16'h0000, 16'h0000); // start below two: no-op
        send_request(K_FREE,  16'd1,     16'h0000, 16'h0000);
        send_request(K_FREE,  16'hFFF8,  16'h0000, 16'h0000); // start at chain end: no-op
        send_request(K_FREE,  16'hFFFF,  16'h0000, 16'h0000);
        send_request(K_FREE,  16'd2,     16'h0000, 16'h0000); // normal two-link chain
        send_request(K_WRITE, 16'd4,     16'h1234, 16'h0000);
        send_request(K_FREE,  16'd4,     16'h0000, 16'h0000); // chain leaves the table
        send_request(K_FREE,  16'hFFF7,  16'h0000, 16'h0000); // start off the table
        send_request(K_FREE,  16'd5,     16'h0000, 16'h0000); // self loop ends once zeroed
        send_request(K_FREE,  16'd4095,  16'h0000, 16'h0000);

        // random phases, one cluster_count each, written with the engine idle;
        // the first phase runs without any idling on either side
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            set_cluster_count(count_plan[phase]);
            idle_on = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                send_random_request();
                // now and then hold the sender until the engine has drained
                if ($urandom_range(0, 99) < 3) settle();
            end
        end

        settle();
        // result path latency plus margin for any stray transfer
        repeat (20) @(posedge i_clk);
        if (fail_total == 0 && pending == 0) begin
            $display("[fat16_cluster_table_engine_unit] OK");
        end else begin
            $display("[fat16_cluster_table_engine_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/fct_pkg.sv
rtl/core/fct_ram.sv
rtl/core/fat16_cluster_table_engine_unit.sv
tb/fat16_cluster_table_engine_unit_checker.sv
tb/fat16_cluster_table_engine_unit_tb.sv
